FILE: rtl/sspq_pkg.sv
// Package for the sorted priority queue: depth, entry and control types, status codes.
`default_nettype none
package sspq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic   insert_en;
        logic   remove_en;
        entry_t item;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/sspq_if.sv
// Request and response channel interfaces of the sorted priority queue.
`default_nettype none
interface sspq_req_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;

    modport source (output valid, mode, item_value, item_priority, input ready);
    modport sink   (input valid, mode, item_value, item_priority, output ready);
endinterface

interface sspq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic signed [15:0] removed_priority;
    logic [4:0]         entry_count;

    modport source (output valid, status, removed_value, removed_priority, entry_count,
                    input ready);
    modport sink   (input valid, status, removed_value, removed_priority, entry_count,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/sspq_cell.sv
// One slot of the sorted chain: holds, shifts right on insert, shifts left on remove.
`default_nettype none
module sspq_cell
    import sspq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire entry_t     left_entry,
    input  wire logic       left_keep,
    input  wire entry_t     right_entry,
    input  wire logic       occupied,
    output      entry_t     entry,
    output      logic       keep
);

    entry_t entry_reg;
    entry_t entry_next;

    // keep: this slot sits ahead of (or ties with) the new entry and stays put
    assign keep  = occupied && (entry_reg.prio <= ctrl.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert_en && !keep)
        begin
            if (left_keep)
            begin
                entry_next = ctrl.item;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (ctrl.remove_en)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

FILE: rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue: chain of slot cells plus count and response register.
//
//  channel | dir | fields
//  --------+-----+--------------------------------------------------------
//  req     | in  | mode, item_value, item_priority
//  rsp     | out | status, removed_value, removed_priority, entry_count
//
// Each request is applied to the whole cell chain in the cycle it is accepted,
// so one request per cycle unless a stalled rsp holds off req; the response appears the next cycle.
// The response register frees when taken, so a stalled rsp only holds off req.
// Reset empties the queue at once (count to zero); slot contents are don't-care.
`default_nettype none
module stable_sorted_priority_queue
    import sspq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sspq_req_if.sink  req,
    sspq_rsp_if.source rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    status_t          status_reg;
    status_t          status_next;
    entry_t           removed_reg;
    entry_t           removed_next;

    logic       req_fire;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    entry_t     cell_entry [DEPTH];
    logic       cell_keep  [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        ctrl.item.value = req.item_value;
        ctrl.item.prio  = req.item_priority;
        ctrl.insert_en  = req_fire && !req.mode && !full;
        ctrl.remove_en  = req_fire && req.mode && !empty;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t left_entry;
            logic   left_keep;
            entry_t right_entry;

            if (i == 0)
            begin : g_head
                // virtual slot ahead of the head always keeps
                assign left_entry = ctrl.item;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_mid
                assign left_entry = cell_entry[i-1];
                assign left_keep  = cell_keep[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_body
                assign right_entry = cell_entry[i+1];
            end

            sspq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .occupied    (count_reg > CNT_W'(i)),
                .entry       (cell_entry[i]),
                .keep        (cell_keep[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_OK;
            removed_next   = '0;
            if (!req.mode)
            begin
                if (full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    removed_next = cell_entry[0];
                    count_next   = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // count is kept separately; its post-request value rides with the response
    logic [CNT_W-1:0] rsp_count_reg;

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_count_reg <= count_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.removed_value    = removed_reg.value;
    assign rsp.removed_priority = removed_reg.prio;
    assign rsp.entry_count      = 5'(rsp_count_reg);

endmodule
`default_nettype wire

FILE: tb/sspq_tb_pkg.sv
// Request mode codes shared by the queue testbench and its checker.
package sspq_tb_pkg;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

endpackage

FILE: tb/sspq_queue_checker.sv
// Checker for the sorted priority queue: mirrors the queue contents and matches every response.
module sspq_queue_checker
    import sspq_pkg::*;
    import sspq_tb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    sspq_req_if       req,
    sspq_rsp_if       rsp,
    output int        mismatches,
    output int        outstanding
);

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [15:0] prio;
        logic [4:0]  count;
    } outcome_t;

    entry_t      slots [DEPTH];
    int unsigned fill;
    outcome_t    awaited_outcomes [$];

    // Apply one request to the mirrored queue and return the response it should produce.
    function automatic outcome_t serve_request(logic mode, entry_t item);
        outcome_t res;
        int unsigned pos;
        res = '0;
        res.status = ST_OK;
        if (mode == MODE_INSERT)
        begin
            if (fill >= DEPTH)
            begin
                res.status = ST_OVERFLOW;
            end
            else
            begin
                // equal priorities stay behind older entries
                pos = 0;
                while (pos < fill && $signed(slots[pos].prio) <= $signed(item.prio))
                begin
                    pos++;
                end
                for (int unsigned i = fill; i > pos; i--)
                begin
                    slots[i] = slots[i - 1];
                end
                slots[pos] = item;
                fill++;
            end
        end
        else
        begin
            if (fill == 0)
            begin
                res.status = ST_UNDERFLOW;
            end
            else
            begin
                res.value = slots[0].value;
                res.prio  = slots[0].prio;
                for (int unsigned i = 1; i < fill; i++)
                begin
                    slots[i - 1] = slots[i];
                end
                fill--;
            end
        end
        res.count = 5'(fill);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        entry_t   item;
        if (!rst_n)
        begin
            fill = 0;
            awaited_outcomes.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            // responses first: a request taken at this edge answers on a later one
            if (rsp.valid && rsp.ready)
            begin
                got.status = status_t'(rsp.status);
                got.value  = rsp.removed_value;
                got.prio   = rsp.removed_priority;
                got.count  = rsp.entry_count;
                if (awaited_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d value %h prio %h count %0d",
                                 got.status, got.value, got.prio, got.count);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected status %0d value %h prio %h count %0d",
                                     want.status, want.value, want.prio, want.count);
                            $display("          actual   status %0d value %h prio %h count %0d",
                                     got.status, got.value, got.prio, got.count);
                        end
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                item.value = req.item_value;
                item.prio  = req.item_priority;
                awaited_outcomes.push_back(serve_request(req.mode, item));
            end
            outstanding = awaited_outcomes.size();
        end
    end

endmodule

FILE: tb/tb_stable_sorted_priority_queue.sv
// Testbench top for the sorted priority queue: reset, request stimulus, response stalls, verdict.
module tb_stable_sorted_priority_queue;
    import sspq_pkg::*;
    import sspq_tb_pkg::*;

    localparam int RANDOM_REQUESTS = 650;
    localparam int CYCLE_LIMIT     = 400000;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          outstanding;
    int unsigned cycles;
    bit          source_idle;
    bit          sink_idle;
    int unsigned stall_left;

    sspq_req_if req_ch ();
    sspq_rsp_if rsp_ch ();

    stable_sorted_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sspq_queue_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 4)) - 16'd2;  // dense ties around zero
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_request(logic mode, logic [31:0] value, logic [15:0] prio);
        int unsigned gap;
        gap = source_idle ? pick_gap() : 0;
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.mode          = mode;
        req_ch.item_value    = value;
        req_ch.item_priority = prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[stable_sorted_priority_queue] ERROR");
            $finish;
        end
    end

    // response side back-pressure, with quiet stretches
    initial
    begin
        rsp_ch.ready = 1'b0;
        stall_left = 0;
        sink_idle = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready = 1'b1;
                if (sink_idle && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
            if ($urandom_range(0, 199) == 0)
                sink_idle = !sink_idle;
        end
    end

    initial
    begin
        int unsigned insert_bias;
        logic        mode;
        cycles               = 0;
        source_idle          = 1'b1;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_INSERT;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // remove from empty
        push_request(MODE_REMOVE, $urandom, 16'($urandom));
        // extremes and ties, filling the queue to the brim
        push_request(MODE_INSERT, 32'h7fffffff, 16'h7fff);
        push_request(MODE_INSERT, 32'h80000000, 16'h8000);
        push_request(MODE_INSERT, 32'h00000000, 16'h0000);
        push_request(MODE_INSERT, 32'h00000001, 16'h0000);
        push_request(MODE_INSERT, 32'h00000002, 16'h0000);
        push_request(MODE_INSERT, 32'hffffffff, 16'hffff);
        push_request(MODE_INSERT, 32'h55555555, 16'h8000);
        push_request(MODE_INSERT, 32'haaaaaaaa, 16'h7fff);
        for (int k = 0; k < 8; k++)
            push_request(MODE_INSERT, $urandom, (k % 2) ? 16'h0001 : 16'hfffe);
        // insert into full
        push_request(MODE_INSERT, 32'h12345678, 16'h8000);
        repeat (4) push_request(MODE_REMOVE, $urandom, 16'($urandom));

        // phases lean toward filling, draining, then balance
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ((n / 50) % 3)
                    0: insert_bias = 85;
                    1: insert_bias = 15;
                    default: insert_bias = 50;
                endcase
                source_idle = ($urandom_range(0, 3) != 0);
            end
            mode = ($urandom_range(0, 99) < insert_bias) ? MODE_INSERT : MODE_REMOVE;
            if ($urandom_range(0, 9) == 0)
                push_request(mode, $urandom_range(0, 1) ? 32'h80000000 : 32'h7fffffff,
                             pick_priority());
            else
                push_request(mode, $urandom, pick_priority());
        end
        req_ch.valid = 1'b0;

        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[stable_sorted_priority_queue] OK");
        else
            $display("[stable_sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
